FILE: sv/fwep_pkg.sv
// Package with the shared types and constants of the four-way equal partition search.
`default_nettype none

package fwep_pkg;

	// Default sizes of the block.
	localparam int MAX_STICKS_DEF  = 32;
	localparam int LENGTH_BITS_DEF = 16;

	// Number of closed sides already recorded when closing one more ends the search.
	localparam logic [1:0] SIDES_BEFORE_LAST = 2'd2;

	// Result status codes.
	localparam logic STATUS_NORMAL   = 1'b0;
	localparam logic STATUS_OVERFLOW = 1'b1;

	// Control of the top level.
	typedef enum logic [1:0] {
		TOP_LOAD,
		TOP_DECIDE,
		TOP_WAIT
	} fwep_top_state_t;

	// Sequencer of the backtracking search.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CHECK,
		S_POP,
		S_POPSTK,
		S_POPLEN,
		S_DUP,
		S_DUPCHK
	} fwep_srch_state_t;

	// Status that the search engine returns to the top level.
	typedef struct packed {
		logic done;
		logic found;
	} fwep_result_t;

endpackage : fwep_pkg

`default_nettype wire

FILE: sv/fwep_search.sv
// Backtracking search engine with the stick memory and the choice stack memory.
`default_nettype none

module fwep_search
	import fwep_pkg::*;
#(
	parameter int MAX_STICKS  = MAX_STICKS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  go,
	input  wire  [$clog2(MAX_STICKS+1)-1:0]      n,
	input  wire  [LENGTH_BITS+$clog2(MAX_STICKS+1)-3:0] target,
	input  wire                                  stick_we,
	input  wire  [$clog2(MAX_STICKS)-1:0]        stick_waddr,
	input  wire  [LENGTH_BITS-1:0]               stick_wdata,
	output fwep_result_t                         res
);

	localparam int IW = $clog2(MAX_STICKS);
	localparam int CW = $clog2(MAX_STICKS + 1);
	localparam int TW = LENGTH_BITS + CW - 2;
	localparam int EW = IW + TW;

	// Memories: lengths of the nonzero sticks, and one stack entry per search level
	// holding the chosen stick and the side sum before it.
	logic [LENGTH_BITS-1:0] stick_mem [MAX_STICKS];
	logic [EW-1:0]          stack_mem [MAX_STICKS];

	logic [LENGTH_BITS-1:0] stick_rd_q;
	logic [EW-1:0]          stack_rd_q;
	logic [IW-1:0]          stick_raddr;
	logic [IW-1:0]          stack_raddr;
	logic                   stack_we;
	logic [IW-1:0]          stack_waddr;
	logic [EW-1:0]          stack_wdata;

	fwep_srch_state_t state_q, state_d;
	logic [CW-1:0]          n_q, n_d;
	logic [TW-1:0]          target_q, target_d;
	logic [CW-1:0]          d_q, d_d;
	logic [CW-1:0]          cursor_q, cursor_d;
	logic [TW-1:0]          base_q, base_d;
	logic [1:0]             sides_q, sides_d;
	logic [MAX_STICKS-1:0]  used_q, used_d;
	logic [IW-1:0]          idx_q, idx_d;
	logic [IW-1:0]          pop_c_q, pop_c_d;
	logic [TW-1:0]          pop_base_q, pop_base_d;
	logic [LENGTH_BITS-1:0] pop_len_q, pop_len_d;
	fwep_result_t           res_q, res_d;

	logic [MAX_STICKS-1:0]  avail;
	logic                   any_avail;
	logic [IW-1:0]          first_idx;
	logic [TW:0]            cand_sum;
	logic [TW:0]            pop_sum;
	logic [CW-1:0]          d_dec;
	logic [IW-1:0]          c_rd;
	logic [TW-1:0]          pb_rd;

	always_ff @(posedge clk) begin
		if (stick_we) begin
			stick_mem[stick_waddr] <= stick_wdata;
		end
		stick_rd_q <= stick_mem[stick_raddr];
	end

	always_ff @(posedge clk) begin
		if (stack_we) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		stack_rd_q <= stack_mem[stack_raddr];
	end

	// Lowest unused stick at or past the cursor.
	always_comb begin
		for (int i = 0; i < MAX_STICKS; i++) begin
			avail[i] = !used_q[i] && (CW'(i) >= cursor_q) && (CW'(i) < n_q);
		end
		any_avail = |avail;
		first_idx = '0;
		for (int i = MAX_STICKS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				first_idx = IW'(i);
			end
		end
	end

	assign cand_sum = {1'b0, base_q} + (TW+1)'(stick_rd_q);
	assign pop_sum  = {1'b0, pop_base_q} + (TW+1)'(stick_rd_q);
	assign d_dec    = d_q - CW'(1);
	assign c_rd     = stack_rd_q[EW-1:TW];
	assign pb_rd    = stack_rd_q[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= '0;
			sides_q <= '0;
			used_q  <= '0;
			d_q     <= '0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			sides_q <= sides_d;
			used_q  <= used_d;
			d_q     <= d_d;
		end
	end

	always_ff @(posedge clk) begin
		n_q        <= n_d;
		target_q   <= target_d;
		cursor_q   <= cursor_d;
		base_q     <= base_d;
		idx_q      <= idx_d;
		pop_c_q    <= pop_c_d;
		pop_base_q <= pop_base_d;
		pop_len_q  <= pop_len_d;
	end

	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		target_d    = target_q;
		d_d         = d_q;
		cursor_d    = cursor_q;
		base_d      = base_q;
		sides_d     = sides_q;
		used_d      = used_q;
		idx_d       = idx_q;
		pop_c_d     = pop_c_q;
		pop_base_d  = pop_base_q;
		pop_len_d   = pop_len_q;
		res_d       = '0;
		res_d.found = res_q.found;
		stick_raddr = '0;
		stack_raddr = '0;
		stack_we    = 1'b0;
		stack_waddr = d_q[IW-1:0];
		stack_wdata = {idx_q, base_q};
		case (state_q)
			S_IDLE: begin
				if (go) begin
					n_d      = n;
					target_d = target;
					d_d      = '0;
					cursor_d = '0;
					base_d   = '0;
					sides_d  = '0;
					used_d   = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (any_avail) begin
					idx_d       = first_idx;
					stick_raddr = first_idx;
					state_d     = S_CHECK;
				end else begin
					state_d = S_POP;
				end
			end
			S_CHECK: begin
				if (cand_sum <= {1'b0, target_q}) begin
					stack_we       = 1'b1;
					used_d[idx_q]  = 1'b1;
					d_d            = d_q + CW'(1);
					state_d        = S_SCAN;
					if (cand_sum == {1'b0, target_q}) begin
						if (sides_q == SIDES_BEFORE_LAST) begin
							res_d.done  = 1'b1;
							res_d.found = 1'b1;
							state_d     = S_IDLE;
						end
						sides_d  = sides_q + 2'd1;
						base_d   = '0;
						cursor_d = '0;
					end else begin
						base_d   = cand_sum[TW-1:0];
						cursor_d = CW'(idx_q) + CW'(1);
					end
				end else if (base_q == '0) begin
					state_d = S_POP;
				end else begin
					cursor_d = CW'(idx_q) + CW'(1);
					state_d  = S_SCAN;
				end
			end
			S_POP: begin
				if (d_q == '0) begin
					res_d.done  = 1'b1;
					res_d.found = 1'b0;
					state_d     = S_IDLE;
				end else begin
					d_d         = d_dec;
					stack_raddr = d_dec[IW-1:0];
					state_d     = S_POPSTK;
				end
			end
			S_POPSTK: begin
				pop_c_d      = c_rd;
				pop_base_d   = pb_rd;
				used_d[c_rd] = 1'b0;
				stick_raddr  = c_rd;
				state_d      = S_POPLEN;
			end
			S_POPLEN: begin
				if (pop_sum == {1'b0, target_q}) begin
					sides_d = sides_q - 2'd1;
				end
				if (pop_base_q == '0) begin
					// A level that opened a side has no other candidate.
					state_d = S_POP;
				end else begin
					pop_len_d = stick_rd_q;
					cursor_d  = CW'(pop_c_q) + CW'(1);
					base_d    = pop_base_q;
					state_d   = S_DUP;
				end
			end
			S_DUP: begin
				if (cursor_q < n_q) begin
					stick_raddr = cursor_q[IW-1:0];
					state_d     = S_DUPCHK;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_DUPCHK: begin
				if (stick_rd_q == pop_len_q) begin
					cursor_d = cursor_q + CW'(1);
					state_d  = S_DUP;
				end else begin
					state_d = S_SCAN;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res = res_q;

	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> (state_q == S_IDLE))
		else $error("search started while busy");

	a_cand_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> !used_q[idx_q])
		else $error("candidate stick already in use");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (d_q <= n_q))
		else $error("stack depth beyond stick count");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_q.done |-> (state_q == S_IDLE))
		else $error("result reported while search still running");

endmodule : fwep_search

`default_nettype wire

FILE: sv/four_way_equal_partition_search.sv
// Top level: stick loading, set checks and result word of the four-way equal partition search.
// Sticks load at one word per cycle with busy low; the last one is followed by a decision
// state, and a set that needs no search (overflow, zero total, total not a multiple of four,
// stick too long) strobes its result in the next cycle. A search steps through candidates,
// stack pops and skips over equal lengths; its result is registered in the engine and again
// at the top before the strobe.
// The strobe lasts one cycle and cannot be stalled; asynchronous active-low reset empties the set.
`default_nettype none

module four_way_equal_partition_search
	import fwep_pkg::*;
#(
	parameter int MAX_STICKS  = MAX_STICKS_DEF,
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire [LENGTH_BITS-1:0] stick_length,
	input  wire                   last_stick,
	output logic                  done,
	output logic                  answer,
	output logic                  status
);

	localparam int IW   = $clog2(MAX_STICKS);
	localparam int CW   = $clog2(MAX_STICKS + 1);
	localparam int TOTW = LENGTH_BITS + CW;
	localparam int TW   = TOTW - 2;

	fwep_top_state_t state_q, state_d;

	// Set accumulators. The stick count covers every accepted stick up to the limit,
	// while only nonzero sticks go to the memory: a zero-length stick fits any side
	// and never changes the answer, so the search does not see it.
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          nz_q;
	logic [TOTW-1:0]        total_q;
	logic [LENGTH_BITS-1:0] max_q;
	logic                   ovf_q;

	logic                   done_q;
	logic                   answer_q;
	logic                   status_q;

	logic                   accept;
	logic                   room;
	logic                   emit;
	logic                   emit_answer;
	logic                   emit_status;
	logic                   search_go;
	logic [TW-1:0]          target;
	fwep_result_t           srch_res;

	assign busy   = (state_q != TOP_LOAD);
	assign accept = start && !busy;
	assign room   = (cnt_q < CW'(MAX_STICKS));
	// A side is a quarter of the total; the low two bits say whether it divides evenly.
	assign target = total_q[TOTW-1:2];

	fwep_search #(
		.MAX_STICKS  (MAX_STICKS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (search_go),
		.n           (nz_q),
		.target      (target),
		.stick_we    (accept && room && (stick_length != '0)),
		.stick_waddr (nz_q[IW-1:0]),
		.stick_wdata (stick_length),
		.res         (srch_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TOP_LOAD;
			cnt_q   <= '0;
			nz_q    <= '0;
			total_q <= '0;
			max_q   <= '0;
			ovf_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
			if (emit) begin
				// The result empties the set for the next one.
				cnt_q   <= '0;
				nz_q    <= '0;
				total_q <= '0;
				max_q   <= '0;
				ovf_q   <= 1'b0;
			end else if (accept) begin
				if (room) begin
					cnt_q   <= cnt_q + CW'(1);
					total_q <= total_q + TOTW'(stick_length);
					if (stick_length != '0) begin
						nz_q <= nz_q + CW'(1);
					end
					if (stick_length > max_q) begin
						max_q <= stick_length;
					end
				end else begin
					// Sticks past the limit are dropped and mark the set as overflowed.
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			answer_q <= emit_answer;
			status_q <= emit_status;
		end
	end

	// Next state and the decision on the finished set.
	always_comb begin
		state_d     = state_q;
		emit        = 1'b0;
		emit_answer = 1'b0;
		emit_status = STATUS_NORMAL;
		search_go   = 1'b0;
		case (state_q)
			TOP_LOAD: begin
				if (accept && last_stick) begin
					state_d = TOP_DECIDE;
				end
			end
			TOP_DECIDE: begin
				state_d = TOP_LOAD;
				if (ovf_q) begin
					emit        = 1'b1;
					emit_status = STATUS_OVERFLOW;
				end else if (total_q == '0) begin
					// Four empty sides.
					emit        = 1'b1;
					emit_answer = 1'b1;
				end else if (total_q[1:0] != 2'b00) begin
					emit = 1'b1;
				end else if (TW'(max_q) > target) begin
					// One stick is longer than a side.
					emit = 1'b1;
				end else begin
					search_go = 1'b1;
					state_d   = TOP_WAIT;
				end
			end
			TOP_WAIT: begin
				if (srch_res.done) begin
					emit        = 1'b1;
					emit_answer = srch_res.found;
					state_d     = TOP_LOAD;
				end
			end
			default: begin
				state_d = TOP_LOAD;
			end
		endcase
	end

	assign done   = done_q;
	assign answer = answer_q;
	assign status = status_q;

endmodule : four_way_equal_partition_search

`default_nettype wire

FILE: tb/tb_four_way_equal_partition_search.sv
// Self-checking testbench for the four-way equal partition search block.
`timescale 1ns / 1ps

module tb_four_way_equal_partition_search;
	import fwep_pkg::*;

	localparam int MAXS  = MAX_STICKS_DEF;
	localparam int LBITS = LENGTH_BITS_DEF;

	// The random part stops once about this many stick words have been sent.
	localparam int STICK_BUDGET = 1150;

	// One expected result word: the verdict on one complete set.
	typedef struct {
		logic answer;
		logic status;
	} verdict_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [LBITS-1:0] stick_length;
	logic             last_stick;
	logic             done;
	logic             answer;
	logic             status;

	// Verdicts predicted for sets already closed but not yet reported by the block.
	verdict_t    verdict_q[$];
	// Sticks of the set that is being loaded, as the block holds them.
	int unsigned open_set[$];
	bit          open_overflow;
	int          sticks_sent;
	int          errors;
	// When low, the sender drives words back to back for the current set.
	bit          gaps_on;

	four_way_equal_partition_search uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.stick_length(stick_length),
		.last_stick  (last_stick),
		.done        (done),
		.answer      (answer),
		.status      (status)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Decides whether the given sticks (at most MAXS of them) form the sides of a square.
	// The search follows the block's algorithm on the sticks sorted longest first: a new side always
	// opens with the first unused stick, and equal lengths are skipped when a level backtracks.
	function automatic bit forms_square(input int unsigned set_sticks[$]);
		longint      len[MAXS];
		longint      total;
		longint      target;
		longint      base;
		longint      next_sum;
		longint      psum[MAXS+1];
		int          choice[MAXS+1];
		bit [MAXS-1:0] used;
		longint      v;
		int          cnt;
		int          n;
		int          i;
		int          j;
		int          k;
		int          c;
		int          depth;
		int          cursor;
		int          sides;
		bit          fits;
		bit          found;
		bit          popped;
		bit          finished;
		bit          verdict;
		cnt = set_sticks.size();
		total = 0;
		for (i = 0; i < cnt; i++) begin
			len[i] = set_sticks[i];
			total += set_sticks[i];
		end
		if (total == 0)
			return 1'b1;
		if (total % 4 != 0)
			return 1'b0;
		target = total / 4;
		// Insertion sort, largest stick first; zero sticks end up at the tail.
		for (i = 1; i < cnt; i++) begin
			v = len[i];
			j = i;
			while (j > 0 && len[j-1] < v) begin
				len[j] = len[j-1];
				j--;
			end
			len[j] = v;
		end
		n = 0;
		fits = 1'b1;
		for (i = 0; i < cnt; i++) begin
			if (len[i] != 0)
				n++;
			if (len[i] > target)
				fits = 1'b0;
		end
		if (!fits)
			return 1'b0;

		depth = 0;
		cursor = 0;
		sides = 0;
		used = '0;
		psum[0] = 0;
		finished = 1'b0;
		verdict = 1'b0;
		while (!finished) begin
			base = psum[depth];
			found = 1'b0;
			for (i = cursor; i < n; i++) begin
				if (used[i])
					continue;
				if (base + len[i] <= target) begin
					found = 1'b1;
					break;
				end
				if (base == 0)
					break;
			end
			if (found && base == 0) begin
				for (k = 0; k < i; k++)
					if (!used[k])
						found = 1'b0;
			end
			if (found) begin
				next_sum = base + len[i];
				used[i] = 1'b1;
				choice[depth] = i;
				if (next_sum == target) begin
					sides++;
					if (sides == 3) begin
						verdict = 1'b1;
						finished = 1'b1;
					end else begin
						psum[depth+1] = 0;
						cursor = 0;
					end
				end else begin
					psum[depth+1] = next_sum;
					cursor = i + 1;
				end
				depth++;
			end else begin
				// Unwind until some level that extends a partial side can try another stick.
				popped = 1'b0;
				while (!popped && !finished) begin
					if (depth == 0) begin
						finished = 1'b1;
					end else begin
						depth--;
						c = choice[depth];
						used[c] = 1'b0;
						if (psum[depth] + len[c] == target)
							sides--;
						if (psum[depth] != 0) begin
							cursor = c + 1;
							while (cursor < n && len[cursor] == len[c])
								cursor++;
							popped = 1'b1;
						end
					end
				end
			end
		end
		return verdict;
	endfunction

	// Sends one stick word and waits until the block takes it. Called and left at a
	// falling edge, so start only changes once per time step.
	task automatic send_stick(input int unsigned len, input bit is_last);
		int       gap;
		int       r;
		verdict_t v;
		gap = 0;
		if (gaps_on) begin
			r = $urandom_range(0, 99);
			if (r >= 92)
				gap = $urandom_range(8, 40);
			else if (r >= 65)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		stick_length <= LBITS'(len);
		last_stick   <= is_last;
		// The word goes in at the first rising edge that sees busy low.
		do
			@(posedge clk);
		while (busy);
		sticks_sent++;
		// Track the set the way the block stores it: sticks past the store only flag overflow.
		if (open_set.size() < MAXS)
			open_set.push_back(len);
		else
			open_overflow = 1'b1;
		if (is_last) begin
			if (open_overflow) begin
				v.answer = 1'b0;
				v.status = STATUS_OVERFLOW;
			end else begin
				v.answer = forms_square(open_set);
				v.status = STATUS_NORMAL;
			end
			verdict_q.push_back(v);
			open_set.delete();
			open_overflow = 1'b0;
		end
		@(negedge clk);
	endtask

	// Sends a whole set with the last word marked; a quarter of the sets go without gaps.
	task automatic send_set(input int unsigned lens[$]);
		int i;
		gaps_on = ($urandom_range(0, 3) != 0);
		for (i = 0; i < lens.size(); i++)
			send_stick(lens[i], i == lens.size() - 1);
	endtask

	// Builds four sides of the given length, each cut into one to max_pieces sticks,
	// and mixes their order.
	function automatic void build_square(output int unsigned q[$], input int unsigned side,
			input int max_pieces);
		int          s;
		int          j;
		int          k;
		int unsigned rest;
		int unsigned piece;
		int unsigned tmp;
		q.delete();
		for (s = 0; s < 4; s++) begin
			k = $urandom_range(1, max_pieces);
			if (k > side)
				k = side;
			rest = side;
			for (j = 0; j < k - 1; j++) begin
				piece = $urandom_range(1, rest - (k - 1 - j));
				q.push_back(piece);
				rest -= piece;
			end
			q.push_back(rest);
		end
		for (j = q.size() - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			tmp = q[j];
			q[j] = q[k];
			q[k] = tmp;
		end
	endfunction

	// Smallest sets: zero total, a plain square, a total that is not a multiple of four,
	// the longest legal sticks, and a stick longer than a side.
	task automatic test_simple_sets();
		int unsigned q[$];
		q = {0};
		send_set(q);
		q = {0, 0, 0};
		send_set(q);
		q = {1, 1, 1, 1};
		send_set(q);
		q = {1, 2};
		send_set(q);
		q = {65535, 65535, 65535, 65535};
		send_set(q);
		q = {9, 1, 1, 1};
		send_set(q);
	endtask

	// Sets where the search has to back up, fails after trying, or skips zero sticks.
	task automatic test_search_paths();
		int unsigned q[$];
		q = {1, 2, 2, 3, 4, 5, 6, 1};
		send_set(q);
		q = {3, 3, 3, 3, 4};
		send_set(q);
		q = {0, 2, 2, 0, 2, 2};
		send_set(q);
	endtask

	// A full store, sets past the store, and a small set right after an overflow.
	task automatic test_capacity();
		int unsigned q[$];
		int          i;
		q.delete();
		for (i = 0; i < MAXS; i++)
			q.push_back(1000);
		send_set(q);
		q.push_back(1000);
		send_set(q);
		q.delete();
		for (i = 0; i < MAXS + 8; i++)
			q.push_back($urandom_range(0, 65535));
		send_set(q);
		q = {7, 7, 7, 7};
		send_set(q);
	endtask

	// Random sets. Half are squares with random content, then squares spoiled by moving
	// one unit between two sticks, raw noise, squares with zero sticks mixed in, full
	// stores and overflowing sets. Large sets are kept easy so the search stays short.
	task automatic test_random_sets();
		int unsigned q[$];
		int unsigned side;
		int          r;
		int          i;
		int          j;
		int          n;
		longint      total;
		while (sticks_sent < STICK_BUDGET) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 9) < 7)
				side = $urandom_range(1, 40);
			else if ($urandom_range(0, 2) != 0)
				side = $urandom_range(41, 5000);
			else
				side = $urandom_range(5001, 65535);
			if (r < 50) begin
				build_square(q, side, 3);
			end else if (r < 65) begin
				build_square(q, side, 2);
				i = $urandom_range(0, q.size() - 1);
				j = $urandom_range(0, q.size() - 1);
				if (i != j && q[i] > 1 && q[j] < 65535) begin
					q[i] = q[i] - 1;
					q[j] = q[j] + 1;
				end
			end else if (r < 80) begin
				q.delete();
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++)
					if ($urandom_range(0, 9) < 7)
						q.push_back($urandom_range(1, 12));
					else
						q.push_back($urandom_range(0, 65535));
			end else if (r < 88) begin
				build_square(q, side, 3);
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++)
					q.insert($urandom_range(0, q.size()), 0);
			end else if (r < 93) begin
				q.delete();
				if ($urandom_range(0, 1) == 1) begin
					side = $urandom_range(1, 65535);
					for (i = 0; i < MAXS; i++)
						q.push_back(side);
				end else begin
					// A full store of random sticks; the total is kept off a multiple of four
					// so the block answers without a long search.
					total = 0;
					for (i = 0; i < MAXS; i++) begin
						q.push_back($urandom_range(0, 65535));
						total += q[i];
					end
					if (total % 4 == 0)
						q[MAXS-1] = q[MAXS-1] ^ 1;
				end
			end else begin
				q.delete();
				n = $urandom_range(MAXS + 1, MAXS + 6);
				for (i = 0; i < n; i++)
					q.push_back($urandom_range(0, 65535));
			end
			send_set(q);
		end
		// A few sticks with no marked last one: they must not produce any result.
		gaps_on = 1'b1;
		for (i = 0; i < 3; i++)
			send_stick($urandom_range(1, 65535), 1'b0);
	endtask

	// Each strobed result word is matched against the oldest predicted verdict.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				$error("result word with no set waiting: answer=%0b status=%0b", answer, status);
				errors++;
			end else begin
				if (answer !== verdict_q[0].answer) begin
					$error("answer: expected %0b, actual %0b", verdict_q[0].answer, answer);
					errors++;
				end
				if (status !== verdict_q[0].status) begin
					$error("status: expected %0b, actual %0b", verdict_q[0].status, status);
					errors++;
				end
				void'(verdict_q.pop_front());
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		stick_length  = '0;
		last_stick    = 1'b0;
		open_overflow = 1'b0;
		sticks_sent   = 0;
		errors        = 0;
		gaps_on       = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_simple_sets();
		test_search_paths();
		test_capacity();
		test_random_sets();

		start <= 1'b0;
		// Let every closed set come back, then watch a little longer for stray strobes.
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Hard stop in case the block hangs or never raises a result.
	initial begin
		#40_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: sim.f
sv/fwep_pkg.sv
sv/fwep_search.sv
sv/four_way_equal_partition_search.sv
tb/tb_four_way_equal_partition_search.sv
